// ----- hdl/cmrm_pkg.sv -----
package cmrm_pkg;

   // tensor shape
   localparam int DIMS       = 4;
   localparam int RANK_LIMIT = 4;
   localparam int RANK_W     = 3;
   localparam int EXT_W      = 13;
   localparam int PROD_W     = 2 * EXT_W;

   // payload and port widths
   localparam int ELEM_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   typedef logic [EXT_W-1:0]     ext_type;
   typedef logic [RANK_W-1:0]    rank_type;
   typedef logic [ELEM_W-1:0]    elem_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // result status codes
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_NOT_LOADED = 2'd1;
   localparam status_type STATUS_FULL       = 2'd2;
   localparam status_type STATUS_BAD_SHAPE  = 2'd3;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // register indexes
   localparam csr_idx_type CSR_RANK = 3'd0;
   localparam csr_idx_type CSR_EXT0 = 3'd1;
   localparam csr_idx_type CSR_EXT1 = 3'd2;
   localparam csr_idx_type CSR_EXT2 = 3'd3;
   localparam csr_idx_type CSR_EXT3 = 3'd4;

   // shape pipeline depth after a register write or reset
   localparam logic [1:0] SETTLE_INIT = 2'd3;

endpackage

// ----- hdl/column_major_to_row_major_reorder_core.sv -----
// column-major to row-major reorder of a tensor of up to four dimensions. load words
// (opcode 0) fill the element buffer in arrival order; once the buffer holds the product
// of the extents in use, each emit word (opcode 1) returns the next element in row-major
// order, flagged last on the final one, after which the block rearms for the next array.
// a load into a full buffer, an emit before the buffer is full, and a bad shape (an extent
// in use of zero, or a product above MAX_ELEMENTS) return a flagged status word with zero
// data. the block takes one word per cycle while req_stall is low; a result appears in the
// output register the cycle after its word is taken, read from the single-port element buffer
// (one write or one registered read per cycle). any register write, and reset, rearm the block
// and hold req_stall high while the three-stage shape multiplier recomputes strides and the
// extent product. the buffer needs no clearing pass.
module column_major_to_row_major_reorder_core #(
   parameter int MAX_ELEMENTS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [cmrm_pkg::ELEM_W-1:0]   req_element_bits,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cmrm_pkg::ELEM_W-1:0]   rsp_element_out,
   output logic                          rsp_last_element,
   output logic [cmrm_pkg::STATUS_W-1:0] rsp_status,
   // register write port
   input  logic                          csr_wr_en,
   input  logic [cmrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmrm_pkg::EXT_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_ELEMENTS);      // buffer address
   localparam int CW = AW + 1;                    // counts up to MAX_ELEMENTS
   localparam int SW = $clog2(MAX_ELEMENTS + 2);  // saturated partial product
   localparam int PW = 2 * SW;                    // full saturated product
   localparam int TW = SW + cmrm_pkg::EXT_W;      // stride3 before truncation

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   cmrm_pkg::rank_type rank_ff;
   cmrm_pkg::ext_type  ext_ff [cmrm_pkg::DIMS];
   logic               cfg_hit;
   logic [1:0]         settle_ff;
   logic [1:0]         settle_in;

   always_comb begin
      cfg_hit = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            cmrm_pkg::CSR_RANK: cfg_hit = 1'b1;
            cmrm_pkg::CSR_EXT0: cfg_hit = 1'b1;
            cmrm_pkg::CSR_EXT1: cfg_hit = 1'b1;
            cmrm_pkg::CSR_EXT2: cfg_hit = 1'b1;
            cmrm_pkg::CSR_EXT3: cfg_hit = 1'b1;
            default:            cfg_hit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= cmrm_pkg::RANK_W'(1);
         for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
            ext_ff[d] <= cmrm_pkg::EXT_W'(1);
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            cmrm_pkg::CSR_RANK: rank_ff   <= csr_wdata[cmrm_pkg::RANK_W-1:0];
            cmrm_pkg::CSR_EXT0: ext_ff[0] <= csr_wdata;
            cmrm_pkg::CSR_EXT1: ext_ff[1] <= csr_wdata;
            cmrm_pkg::CSR_EXT2: ext_ff[2] <= csr_wdata;
            cmrm_pkg::CSR_EXT3: ext_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // settle counter: input held off until the shape pipeline reflects the new registers
   always_comb begin
      if (cfg_hit) begin
         settle_in = cmrm_pkg::SETTLE_INIT;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= cmrm_pkg::SETTLE_INIT;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // ------------------------------------------------------------------
   // shape pipeline: effective extents, strides, product, bad-shape flag
   // ------------------------------------------------------------------
   cmrm_pkg::rank_type used_rank;
   cmrm_pkg::ext_type  eff_in [cmrm_pkg::DIMS];
   cmrm_pkg::ext_type  eff_ff [cmrm_pkg::DIMS];
   logic [cmrm_pkg::PROD_W-1:0] s01_ff;
   logic [cmrm_pkg::PROD_W-1:0] s23_ff;
   logic [SW-1:0]      s01_sat;
   logic [SW-1:0]      s23_sat;
   logic [TW-1:0]      stride3_full;
   logic [PW-1:0]      prod_full;
   logic [CW-1:0]      stride3_ff;
   logic [PW-1:0]      prod_ff;
   logic [CW-1:0]      stride [cmrm_pkg::DIMS+1];
   logic               shape_bad_ff;
   logic [CW-1:0]      total_ff;
   logic [CW-1:0]      delta_ff [cmrm_pkg::DIMS];

   // rank 0 counts as 1, rank above the limit as the limit
   always_comb begin
      used_rank = rank_ff;
      if (rank_ff == cmrm_pkg::RANK_W'(0)) begin
         used_rank = cmrm_pkg::RANK_W'(1);
      end else if (rank_ff > cmrm_pkg::RANK_W'(cmrm_pkg::RANK_LIMIT)) begin
         used_rank = cmrm_pkg::RANK_W'(cmrm_pkg::RANK_LIMIT);
      end
      for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
         eff_in[d] = (cmrm_pkg::RANK_W'(d) < used_rank) ? ext_ff[d] : cmrm_pkg::EXT_W'(1);
      end
   end

   // stage a: pairwise products
   always_ff @(posedge clock) begin
      for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
         eff_ff[d] <= eff_in[d];
      end
      s01_ff <= cmrm_pkg::PROD_W'(eff_in[0]) * cmrm_pkg::PROD_W'(eff_in[1]);
      s23_ff <= cmrm_pkg::PROD_W'(eff_in[2]) * cmrm_pkg::PROD_W'(eff_in[3]);
   end

   // stage b: saturate above capacity, then stride3 and the full product
   always_comb begin
      s01_sat = (s01_ff > cmrm_pkg::PROD_W'(MAX_ELEMENTS)) ? SW'(MAX_ELEMENTS + 1) : SW'(s01_ff);
      s23_sat = (s23_ff > cmrm_pkg::PROD_W'(MAX_ELEMENTS)) ? SW'(MAX_ELEMENTS + 1) : SW'(s23_ff);
      stride3_full = TW'(s01_sat) * TW'(eff_ff[2]);
      prod_full    = PW'(s01_sat) * PW'(s23_sat);
   end

   always_ff @(posedge clock) begin
      stride3_ff <= CW'(stride3_full);
      prod_ff    <= prod_full;
   end

   // stage c: address step per carry position
   // step when dim k increments and all faster dims wrap: stride[k] + stride[k+1] - total
   always_comb begin
      stride[0] = CW'(1);
      stride[1] = CW'(eff_ff[0]);
      stride[2] = CW'(s01_ff);
      stride[3] = stride3_ff;
      stride[4] = CW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      shape_bad_ff <= (prod_ff == PW'(0)) || (prod_ff > PW'(MAX_ELEMENTS));
      total_ff     <= CW'(prod_ff);
      for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
         delta_ff[d] <= stride[d] + stride[d+1] - CW'(prod_ff);
      end
   end

   // ------------------------------------------------------------------
   // element buffer, counters and odometer
   // ------------------------------------------------------------------
   cmrm_pkg::elem_type element_store_mem [MAX_ELEMENTS];
   cmrm_pkg::elem_type mem_rd_ff;

   logic [CW-1:0]      loaded_ff,  loaded_in;
   logic [CW-1:0]      emitted_ff, emitted_in;
   logic [CW-1:0]      addr_ff,    addr_in;
   cmrm_pkg::ext_type  coord_ff [cmrm_pkg::DIMS];
   cmrm_pkg::ext_type  coord_in [cmrm_pkg::DIMS];
   logic [cmrm_pkg::DIMS-1:0] wrap;
   logic [cmrm_pkg::DIMS-1:0] carry;
   logic [1:0]         step_sel;

   logic               req_acc;
   logic               mem_we;
   logic               mem_re;
   logic               res_fire;
   cmrm_pkg::status_type res_status;
   logic               res_last;

   logic               rsp_valid_ff, rsp_valid_in;
   cmrm_pkg::status_type rsp_status_ff;
   logic               rsp_last_ff;
   logic               rsp_data_ok_ff;

   // a word is taken when no register write or settle is pending and the output register is free or drains this cycle
   assign req_stall = (settle_ff != 2'd0) || csr_wr_en || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;

   // odometer carry chain, fastest dimension last
   always_comb begin
      for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
         wrap[d] = (coord_ff[d] == (eff_ff[d] - cmrm_pkg::EXT_W'(1)));
      end
      carry[cmrm_pkg::DIMS-1] = 1'b1;
      for (int d = cmrm_pkg::DIMS - 2; d >= 0; d--) begin
         carry[d] = carry[d+1] && wrap[d+1];
      end
      step_sel = 2'd0;
      for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
         if (carry[d] && !wrap[d]) begin
            step_sel = 2'(d);
         end
      end
   end

   always_comb begin
      loaded_in  = loaded_ff;
      emitted_in = emitted_ff;
      addr_in    = addr_ff;
      for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
         coord_in[d] = coord_ff[d];
      end
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      res_fire   = 1'b0;
      res_status = cmrm_pkg::STATUS_OK;
      res_last   = 1'b0;

      if (cfg_hit) begin
         // rearm for a new array
         loaded_in  = '0;
         emitted_in = '0;
         addr_in    = '0;
         for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
            coord_in[d] = '0;
         end
      end else if (req_acc) begin
         if (shape_bad_ff) begin
            res_fire   = 1'b1;
            res_status = cmrm_pkg::STATUS_BAD_SHAPE;
         end else begin
            case (req_opcode)
               cmrm_pkg::OP_LOAD: begin
                  if (loaded_ff >= total_ff) begin
                     res_fire   = 1'b1;
                     res_status = cmrm_pkg::STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     loaded_in = loaded_ff + CW'(1);
                  end
               end
               cmrm_pkg::OP_EMIT: begin
                  res_fire = 1'b1;
                  if (loaded_ff < total_ff) begin
                     res_status = cmrm_pkg::STATUS_NOT_LOADED;
                  end else begin
                     mem_re = 1'b1;
                     if (emitted_ff == (total_ff - CW'(1))) begin
                        // final element: rearm
                        res_last   = 1'b1;
                        loaded_in  = '0;
                        emitted_in = '0;
                        addr_in    = '0;
                        for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
                           coord_in[d] = '0;
                        end
                     end else begin
                        emitted_in = emitted_ff + CW'(1);
                        addr_in    = addr_ff + delta_ff[step_sel];
                        for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
                           if (carry[d]) begin
                              coord_in[d] = wrap[d] ? '0 : coord_ff[d] + cmrm_pkg::EXT_W'(1);
                           end
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff  <= '0;
         emitted_ff <= '0;
         addr_ff    <= '0;
         for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
            coord_ff[d] <= '0;
         end
      end else begin
         loaded_ff  <= loaded_in;
         emitted_ff <= emitted_in;
         addr_ff    <= addr_in;
         for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
            coord_ff[d] <= coord_in[d];
         end
      end
   end

   // loads and emits never overlap on one array, so a read always follows its write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         element_store_mem[loaded_ff[AW-1:0]] <= req_element_bits;
      end
      if (mem_re) begin
         mem_rd_ff <= element_store_mem[addr_ff[AW-1:0]];
      end
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   always_comb begin
      if (res_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_status_ff  <= res_status;
         rsp_last_ff    <= res_last;
         rsp_data_ok_ff <= (res_status == cmrm_pkg::STATUS_OK);
      end
   end

   // buffer read data sits in mem_rd_ff; error words carry zero
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last_element = rsp_last_ff;
   assign rsp_element_out  = rsp_data_ok_ff ? mem_rd_ff : '0;

endmodule

// ----- hdl/cmrm_checker.sv -----
module cmrm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [cmrm_pkg::ELEM_W-1:0]    rsp_element_out,
   input logic                           rsp_last_element,
   input logic [cmrm_pkg::STATUS_W-1:0]  rsp_status,
   input logic                           csr_wr_en,
   input logic [cmrm_pkg::CSR_IDX_W-1:0] csr_index
);

   // a stalled response word stays offered
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   // error words carry zero data and no last flag
   rsp_err_zero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cmrm_pkg::STATUS_OK) |->
         (rsp_element_out == '0) && !rsp_last_element)
      else $error("error word carries data or last flag");

   // last flag only on a good emit
   rsp_last_ok_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_element |-> rsp_status == cmrm_pkg::STATUS_OK)
      else $error("last flag on a flagged word");

   // input held off while the shape settles after a register write
   cfg_settle_a: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && (csr_index <= cmrm_pkg::CSR_EXT3) |=> req_stall)
      else $error("request taken right after register write");

   // a new response word follows a taken request word
   rsp_cause_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response word without a request word");

endmodule

bind column_major_to_row_major_reorder_core cmrm_checker u_cmrm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_element_out  (rsp_element_out),
   .rsp_last_element (rsp_last_element),
   .rsp_status       (rsp_status),
   .csr_wr_en        (csr_wr_en),
   .csr_index        (csr_index)
);

// ----- tb/reorder_scoreboard.sv -----
`timescale 1ns / 100ps

module reorder_scoreboard #(
   parameter int MAX_ELEMENTS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_opcode,
   input  cmrm_pkg::elem_type    req_element_bits,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cmrm_pkg::elem_type    rsp_element_out,
   input  logic                  rsp_last_element,
   input  cmrm_pkg::status_type  rsp_status,
   input  logic                  csr_wr_en,
   input  cmrm_pkg::csr_idx_type csr_index,
   input  cmrm_pkg::ext_type     csr_wdata,
   output int                    mismatch_count,
   output int                    pending_words
);

   typedef struct packed {
      cmrm_pkg::elem_type   element;
      logic                 last;
      cmrm_pkg::status_type status;
   } reorder_word_type;

   // shape registers as the block holds them
   cmrm_pkg::rank_type cfg_rank;
   cmrm_pkg::ext_type  cfg_extent [cmrm_pkg::DIMS];

   // mirror of the element buffer and the odometer
   cmrm_pkg::elem_type element_mirror [MAX_ELEMENTS];
   int       loaded_words;
   int       emitted_words;
   int       coord [cmrm_pkg::DIMS];
   int       source_index;

   reorder_word_type expected_words [$];

   function automatic void append_word(reorder_word_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic int used_rank();
      int r;
      r = cfg_rank;
      if (r < 1) r = 1;
      if (r > cmrm_pkg::RANK_LIMIT) r = cmrm_pkg::RANK_LIMIT;
      return r;
   endfunction

   function automatic longint extent_in_use(int d);
      return (d >= used_rank()) ? 64'd1 : longint'(cfg_extent[d]);
   endfunction

   function automatic longint shape_product();
      longint p;
      p = 1;
      for (int d = 0; d < cmrm_pkg::DIMS; d++) p = p * extent_in_use(d);
      return p;
   endfunction

   function automatic void rearm_odometer();
      loaded_words  = 0;
      emitted_words = 0;
      source_index  = 0;
      for (int d = 0; d < cmrm_pkg::DIMS; d++) coord[d] = 0;
   endfunction

   // row-major step, address rebuilt from column-major strides
   function automatic void advance_odometer();
      longint stride [cmrm_pkg::DIMS];
      longint addr;
      stride[0] = 1;
      for (int d = 1; d < cmrm_pkg::DIMS; d++) stride[d] = stride[d-1] * extent_in_use(d - 1);
      for (int k = cmrm_pkg::DIMS - 1; k >= 0; k--) begin
         coord[k]++;
         if (coord[k] < extent_in_use(k)) break;
         coord[k] = 0;
      end
      addr = 0;
      for (int d = 0; d < cmrm_pkg::DIMS; d++) addr = addr + coord[d] * stride[d];
      source_index = int'(addr);
   endfunction

   function automatic void predict_reorder(logic op, cmrm_pkg::elem_type bits);
      longint           words;
      reorder_word_type flagged;
      words   = shape_product();
      flagged = '0;
      if (words == 0 || words > MAX_ELEMENTS) begin
         flagged.status = cmrm_pkg::STATUS_BAD_SHAPE;
         append_word(flagged);
      end else if (op == cmrm_pkg::OP_LOAD) begin
         if (loaded_words >= words) begin
            flagged.status = cmrm_pkg::STATUS_FULL;
            append_word(flagged);
         end else begin
            element_mirror[loaded_words] = bits;
            loaded_words++;
         end
      end else if (loaded_words < words) begin
         flagged.status = cmrm_pkg::STATUS_NOT_LOADED;
         append_word(flagged);
      end else begin
         flagged.element = element_mirror[source_index];
         flagged.status  = cmrm_pkg::STATUS_OK;
         if (emitted_words + 1 >= words) begin
            flagged.last = 1'b1;
            rearm_odometer();
         end else begin
            emitted_words++;
            advance_odometer();
         end
         append_word(flagged);
      end
   endfunction

   always @(posedge clock) begin
      reorder_word_type want;
      if (reset) begin
         cfg_rank = 1;
         for (int d = 0; d < cmrm_pkg::DIMS; d++) cfg_extent[d] = 1;
         rearm_odometer();
         expected_words.delete();
         mismatch_count = 0;
      end else begin
         // results first: a result never belongs to the word taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word element_out=%h last=%b status=%0d",
                        $time, rsp_element_out, rsp_last_element, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_element_out !== want.element) begin
                  $display("%0t: element_out expected %h got %h",
                           $time, want.element, rsp_element_out);
                  mismatch_count++;
               end
               if (rsp_last_element !== want.last) begin
                  $display("%0t: last_element expected %b got %b",
                           $time, want.last, rsp_last_element);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               cmrm_pkg::CSR_RANK: begin
                  cfg_rank = csr_wdata[cmrm_pkg::RANK_W-1:0];
                  rearm_odometer();
               end
               cmrm_pkg::CSR_EXT0, cmrm_pkg::CSR_EXT1, cmrm_pkg::CSR_EXT2,
               cmrm_pkg::CSR_EXT3: begin
                  cfg_extent[csr_index - cmrm_pkg::CSR_EXT0] = csr_wdata;
                  rearm_odometer();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_reorder(req_opcode, req_element_bits);
      end
      pending_words = expected_words.size();
   end

endmodule

// ----- tb/tb_column_major_to_row_major_reorder_core.sv -----
`timescale 1ns / 100ps

module tb_column_major_to_row_major_reorder_core;

   localparam int     ELEMENTS         = 4096;
   // covers the write cycle, the three-stage shape pipeline and a buffer write in flight
   localparam int     SETTLE_CYCLES    = 8;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam int     RANDOM_WORDS     = 2000;
   // watchdog limit, well above the slowest run
   localparam longint WATCHDOG_NS      = 40_000_000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_opcode;
   cmrm_pkg::elem_type    req_element_bits;
   logic                  rsp_valid;
   logic                  rsp_stall;
   cmrm_pkg::elem_type    rsp_element_out;
   logic                  rsp_last_element;
   cmrm_pkg::status_type  rsp_status;
   logic                  csr_wr_en;
   cmrm_pkg::csr_idx_type csr_index;
   cmrm_pkg::ext_type     csr_wdata;

   int     mismatch_count;
   int     pending_words;
   int     words_sent;
   bit     no_gaps;      // burst mode: sender never idles
   bit     long_hold;    // asks the receiver for one long hold-off
   longint array_words;  // element count of the current shape
   bit     shape_ok;

   column_major_to_row_major_reorder_core #(
      .MAX_ELEMENTS(ELEMENTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_element_bits (req_element_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element_out  (rsp_element_out),
      .rsp_last_element (rsp_last_element),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // watches both channels and the register port, predicts and compares
   reorder_scoreboard #(
      .MAX_ELEMENTS(ELEMENTS)
   ) scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("timeout: reorder core stopped making progress");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one word at the falling edge and hold it until the core takes it
   task automatic send_word(input logic op, input cmrm_pkg::elem_type bits);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_element_bits <= bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // sender pauses until every predicted result is back, then lets the core settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write all five shape registers back to back while the core is idle
   task automatic write_shape(input int r, input int e0, input int e1, input int e2,
                              input int e3);
      int ext [cmrm_pkg::DIMS];
      int ur;
      drain();
      ext = '{e0, e1, e2, e3};
      // rank only uses its low bits; the rest of the data word is noise
      csr_wr_en <= 1'b1;
      csr_index <= cmrm_pkg::CSR_RANK;
      csr_wdata <= cmrm_pkg::ext_type'(($urandom_range(0, 1023) << cmrm_pkg::RANK_W) | r);
      @(negedge clock);
      csr_index <= cmrm_pkg::CSR_EXT0;
      csr_wdata <= cmrm_pkg::ext_type'(e0);
      @(negedge clock);
      csr_index <= cmrm_pkg::CSR_EXT1;
      csr_wdata <= cmrm_pkg::ext_type'(e1);
      @(negedge clock);
      csr_index <= cmrm_pkg::CSR_EXT2;
      csr_wdata <= cmrm_pkg::ext_type'(e2);
      @(negedge clock);
      csr_index <= cmrm_pkg::CSR_EXT3;
      csr_wdata <= cmrm_pkg::ext_type'(e3);
      @(negedge clock);
      // now and then poke an index past the last register; it must change nothing
      if ($urandom_range(0, 3) == 0) begin
         csr_index <= cmrm_pkg::csr_idx_type'(cmrm_pkg::CSR_EXT3 + $urandom_range(1, 3));
         csr_wdata <= cmrm_pkg::ext_type'($urandom);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      ur = (r < 1) ? 1 : (r > cmrm_pkg::RANK_LIMIT) ? cmrm_pkg::RANK_LIMIT : r;
      array_words = 1;
      for (int d = 0; d < ur; d++) array_words = array_words * ext[d];
      shape_ok = (array_words != 0) && (array_words <= ELEMENTS);
   endtask

   // one array: column-major loads then row-major emits, with occasional stray words;
   // a broken array stops halfway through the emits
   task automatic run_array(input bit broken, input int hold_at);
      int n;
      n = int'(array_words);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 49) == 0) send_word(cmrm_pkg::OP_EMIT, $urandom);  // early emit
         send_word(cmrm_pkg::OP_LOAD, $urandom);
      end
      if ($urandom_range(0, 9) == 0) send_word(cmrm_pkg::OP_LOAD, $urandom);     // overfill
      for (int i = 0; i < n; i++) begin
         if (broken && i == n / 2) return;
         if (i == hold_at) long_hold = 1'b1;
         send_word(cmrm_pkg::OP_EMIT, $urandom);
      end
   endtask

   // receiver: random stall pattern, plus one long hold-off on request
   initial begin
      int r;
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_stall <= 1'b0;
               n = $urandom_range(1, 6);
            end else if (r < 85) begin
               rsp_stall <= 1'b1;
               n = $urandom_range(1, 3);
            end else if (r < 95) begin
               rsp_stall <= 1'b0;      // quiet stretch, no stalls at all
               n = $urandom_range(20, 60);
            end else begin
               rsp_stall <= 1'b1;
               n = $urandom_range(8, 30);
            end
            repeat (n) @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      int kind;
      int r;
      int ur;
      int ext [cmrm_pkg::DIMS];
      bit big_used;
      req_valid        = 1'b0;
      req_opcode       = cmrm_pkg::OP_LOAD;
      req_element_bits = '0;
      csr_wr_en        = 1'b0;
      csr_index        = cmrm_pkg::CSR_RANK;
      csr_wdata        = '0;
      long_hold        = 1'b0;
      no_gaps          = 1'b1;
      words_sent       = 0;
      array_words      = 1;
      shape_ok         = 1'b1;
      reset            = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset shape is a single element
      send_word(cmrm_pkg::OP_EMIT, 32'h1234_5678);   // nothing loaded yet
      send_word(cmrm_pkg::OP_LOAD, 32'hFFFF_FFFF);
      send_word(cmrm_pkg::OP_LOAD, 32'h0000_0000);   // buffer already full
      send_word(cmrm_pkg::OP_EMIT, 32'h0000_0000);   // all ones back, flagged last
      send_word(cmrm_pkg::OP_EMIT, 32'hFFFF_FFFF);   // rearmed, so not loaded again
      send_word(cmrm_pkg::OP_LOAD, 32'h0000_0000);
      send_word(cmrm_pkg::OP_EMIT, 32'hFFFF_FFFF);

      // 2x3 matrix; unused extents hold junk, including zero and the top value
      write_shape(2, 2, 3, 0, 8191);
      for (int i = 0; i < 6; i++) begin
         if (i == 3) send_word(cmrm_pkg::OP_EMIT, $urandom);   // half loaded
         send_word(cmrm_pkg::OP_LOAD, $urandom);
      end
      for (int i = 0; i < 6; i++) send_word(cmrm_pkg::OP_EMIT, $urandom);

      // rank zero counts as one, and its only extent is zero
      write_shape(0, 0, 5, 5, 5);
      send_word(cmrm_pkg::OP_LOAD, $urandom);
      send_word(cmrm_pkg::OP_EMIT, $urandom);

      // rank above the limit counts as four; product overshoots the buffer
      write_shape(7, 4096, 2, 1, 1);
      send_word(cmrm_pkg::OP_EMIT, $urandom);
      send_word(cmrm_pkg::OP_LOAD, $urandom);

      // 4-d array; the receiver holds off partway through the emits
      // so the output fills and the core stalls its input
      no_gaps = 1'b0;
      write_shape(4, 4, 4, 4, 4);
      run_array(1'b0, 100);
      drain();

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         no_gaps  = ($urandom_range(0, 4) == 0);
         kind     = $urandom_range(0, 99);
         r        = $urandom_range(0, 7);
         ur       = (r < 1) ? 1 : (r > cmrm_pkg::RANK_LIMIT) ? cmrm_pkg::RANK_LIMIT : r;
         big_used = 1'b0;
         if (kind < 75) begin
            // well-formed small shape, at most one larger extent, unused extents random
            for (int d = 0; d < cmrm_pkg::DIMS; d++) begin
               if (d >= ur) ext[d] = $urandom_range(0, 8191);
               else if (!big_used && $urandom_range(0, 9) == 0) begin
                  ext[d]   = $urandom_range(5, 12);
                  big_used = 1'b1;
               end
               else ext[d] = $urandom_range(1, 4);
            end
            write_shape(r, ext[0], ext[1], ext[2], ext[3]);
            if (shape_ok) begin
               repeat ($urandom_range(1, 3)) run_array($urandom_range(0, 9) == 0, -1);
            end else begin
               repeat ($urandom_range(2, 6)) send_word(1'($urandom_range(0, 1)), $urandom);
            end
         end else if (kind < 90) begin
            // bad shape: an extent in use of zero or one that overshoots on its own
            for (int d = 0; d < cmrm_pkg::DIMS; d++) ext[d] = $urandom_range(0, 8191);
            ext[$urandom_range(0, ur - 1)] = ($urandom_range(0, 1) == 0) ? 0 : 8191;
            write_shape(r, ext[0], ext[1], ext[2], ext[3]);
            repeat ($urandom_range(2, 6)) send_word(1'($urandom_range(0, 1)), $urandom);
         end else begin
            // largest single extent: load a few words, then an emit that is too early
            write_shape(1, 4096, $urandom_range(0, 8191), $urandom_range(0, 8191),
                        $urandom_range(0, 8191));
            repeat ($urandom_range(1, 5)) send_word(cmrm_pkg::OP_LOAD, $urandom);
            send_word(cmrm_pkg::OP_EMIT, $urandom);
         end
      end

      drain();
      if (mismatch_count == 0 && pending_words == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
